FILE: src/qtt_pkg.sv
// Shared types and constants for the query text tokenizer.
// Used by query_text_tokenizer and its testbench; depends on nothing else.
package qtt_pkg;

  localparam int unsigned MAX_ARGS = 9;
  localparam int unsigned MASK_W   = 9;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_ARG  = 2'd2
  } kind_t;

  // Byte held back for one item to look at the next one
  typedef enum logic [1:0] {
    LA_NONE    = 2'd0,
    LA_SLASH   = 2'd1,
    LA_PERCENT = 2'd2
  } lookahead_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ARG_COUNT = 2'd0,
    REG_ARG_MASK  = 2'd1
  } reg_idx_t;

  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DIGIT1  = 8'h31;
  localparam logic [7:0] CH_DIGIT9  = 8'h39;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_CR      = 8'h0d;

  typedef struct packed {
    logic       in_quote;
    logic       quote_is_double;
    logic       escape_pending;
    logic       in_comment;
    lookahead_t lookahead;
    logic       has_content;
  } scan_state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [3:0] arg_index;
    logic       last;
  } result_t;

  localparam int unsigned MAX_RESULTS = 3;

endpackage

FILE: src/query_text_tokenizer.sv
// Query text tokenizer: scanner state, per-byte decode and result buffer.
// Depends on qtt_pkg.
//
// Each accepted byte is decoded in the cycle it is accepted, and the zero to three
// results it causes are loaded into a three-entry result buffer that drives the
// output channel. A byte causing at most one result lets the next byte in as that
// result is taken, so such bytes stream back to back, and a byte causing more holds
// the input while the buffer drains; results leave one per cycle while out_tready is
// high. Configuration writes are always taken and must only be made while no results are outstanding.
module query_text_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tlast,   // end_of_query
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [11:8] arg_index, [15:12] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,  // run_last
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  logic [qtt_pkg::CNT_W-1:0]  arg_count_r;
  logic [qtt_pkg::MASK_W-1:0] arg_mask_r;

  qtt_pkg::scan_state_t st_r, st_nxt;
  qtt_pkg::result_t     buf_r   [qtt_pkg::MAX_RESULTS];
  qtt_pkg::result_t     res_nxt [qtt_pkg::MAX_RESULTS];
  logic [1:0]           res_cnt;
  logic [1:0]           rem_r, rem_nxt;
  logic [1:0]           ptr_r, ptr_nxt;

  logic in_fire, out_fire;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = (rem_r != 2'd0);
  assign out_fire   = out_tvalid & out_tready;
  assign in_tready  = (rem_r == 2'd0) | ((rem_r == 2'd1) & out_tready);
  assign in_fire    = in_tvalid & in_tready;

  assign out_tdata = {4'd0, buf_r[ptr_r].arg_index, buf_r[ptr_r].data};
  assign out_tuser = buf_r[ptr_r].kind;
  assign out_tlast = buf_r[ptr_r].last;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arg_count_r <= '0;
      arg_mask_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qtt_pkg::REG_ARG_COUNT: arg_count_r <= cfg_data[qtt_pkg::CNT_W-1:0];
        qtt_pkg::REG_ARG_MASK:  arg_mask_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode one byte against the scanner state
  always_comb begin
    logic [7:0]                 c;
    logic                       go_plain;
    logic [3:0]                 idx;
    logic [3:0]                 count;
    logic [qtt_pkg::MASK_W-1:0] mask_sh;
    logic [7:0]                 close_q;

    c        = in_tdata;
    st_nxt   = st_r;
    res_cnt  = 2'd0;
    go_plain = 1'b1;
    idx      = c[3:0] - 4'd1;
    count    = (arg_count_r > 4'(qtt_pkg::MAX_ARGS)) ? 4'(qtt_pkg::MAX_ARGS) : arg_count_r;
    mask_sh  = arg_mask_r >> idx;
    close_q  = st_r.quote_is_double ? qtt_pkg::CH_DQUOTE : qtt_pkg::CH_SQUOTE;
    for (int i = 0; i < qtt_pkg::MAX_RESULTS; i++) begin
      res_nxt[i] = '{kind: qtt_pkg::KIND_BYTE, data: 8'd0, arg_index: 4'd0, last: 1'b0};
    end

    if (st_r.in_comment) begin
      if (c == qtt_pkg::CH_LF) st_nxt.in_comment = 1'b0;
      go_plain = 1'b0;
    end else if (st_r.lookahead == qtt_pkg::LA_SLASH) begin
      st_nxt.lookahead = qtt_pkg::LA_NONE;
      if (c == qtt_pkg::CH_SLASH) begin
        st_nxt.in_comment = 1'b1;
        go_plain = 1'b0;
      end else begin
        res_nxt[res_cnt].data = qtt_pkg::CH_SLASH;
        res_cnt = res_cnt + 2'd1;
        st_nxt.has_content = 1'b1;
      end
    end else if (st_r.lookahead == qtt_pkg::LA_PERCENT) begin
      st_nxt.lookahead = qtt_pkg::LA_NONE;
      if (c >= qtt_pkg::CH_DIGIT1 && c <= qtt_pkg::CH_DIGIT9) begin
        go_plain = 1'b0;
        if (idx < count) begin
          res_nxt[res_cnt].kind      = qtt_pkg::KIND_ARG;
          res_nxt[res_cnt].arg_index = idx;
          res_cnt = res_cnt + 2'd1;
          if (mask_sh[0]) st_nxt.has_content = 1'b1;
        end
      end else begin
        res_nxt[res_cnt].data = qtt_pkg::CH_PERCENT;
        res_cnt = res_cnt + 2'd1;
        st_nxt.has_content = 1'b1;
      end
    end else begin
      st_nxt.lookahead = qtt_pkg::LA_NONE;
    end

    if (go_plain) begin
      if (st_r.escape_pending) begin
        st_nxt.escape_pending = 1'b0;
        res_nxt[res_cnt].data = c;
        res_cnt = res_cnt + 2'd1;
        st_nxt.has_content = 1'b1;
      end else if (c == qtt_pkg::CH_BSLASH) begin
        st_nxt.escape_pending = 1'b1;
      end else if (!st_r.in_quote &&
                   (c == qtt_pkg::CH_SQUOTE || c == qtt_pkg::CH_DQUOTE)) begin
        st_nxt.in_quote        = 1'b1;
        st_nxt.quote_is_double = (c == qtt_pkg::CH_DQUOTE);
      end else if (st_r.in_quote && c == close_q) begin
        // a closing quote ends the token even when it is empty
        st_nxt.in_quote = 1'b0;
        res_nxt[res_cnt].kind = qtt_pkg::KIND_END;
        res_cnt = res_cnt + 2'd1;
        st_nxt.has_content = 1'b0;
      end else if (st_r.in_quote) begin
        res_nxt[res_cnt].data = c;
        res_cnt = res_cnt + 2'd1;
        st_nxt.has_content = 1'b1;
      end else if (c == qtt_pkg::CH_HASH) begin
        st_nxt.in_comment = 1'b1;
      end else if (c == qtt_pkg::CH_SLASH) begin
        st_nxt.lookahead = qtt_pkg::LA_SLASH;
      end else if (c == qtt_pkg::CH_PERCENT) begin
        st_nxt.lookahead = qtt_pkg::LA_PERCENT;
      end else if (c == qtt_pkg::CH_SPACE || c == qtt_pkg::CH_TAB ||
                   c == qtt_pkg::CH_LF || c == qtt_pkg::CH_CR) begin
        if (st_nxt.has_content) begin
          res_nxt[res_cnt].kind = qtt_pkg::KIND_END;
          res_cnt = res_cnt + 2'd1;
          st_nxt.has_content = 1'b0;
        end
      end else begin
        res_nxt[res_cnt].data = c;
        res_cnt = res_cnt + 2'd1;
        st_nxt.has_content = 1'b1;
      end
    end

    // End of query: flush a held byte, close the token, return to reset state
    if (in_tlast) begin
      if (st_nxt.lookahead == qtt_pkg::LA_SLASH) begin
        res_nxt[res_cnt].data = qtt_pkg::CH_SLASH;
        res_cnt = res_cnt + 2'd1;
        st_nxt.has_content = 1'b1;
      end else if (st_nxt.lookahead == qtt_pkg::LA_PERCENT) begin
        res_nxt[res_cnt].data = qtt_pkg::CH_PERCENT;
        res_cnt = res_cnt + 2'd1;
        st_nxt.has_content = 1'b1;
      end
      if (st_nxt.has_content) begin
        res_nxt[res_cnt].kind = qtt_pkg::KIND_END;
        res_cnt = res_cnt + 2'd1;
      end
      st_nxt = '{in_quote: 1'b0, quote_is_double: 1'b0, escape_pending: 1'b0,
                 in_comment: 1'b0, lookahead: qtt_pkg::LA_NONE, has_content: 1'b0};
    end

    if (res_cnt != 2'd0) res_nxt[res_cnt - 2'd1].last = 1'b1;
  end

  // Result buffer pointers; hold the pointer on the final result of a run
  always_comb begin
    rem_nxt = rem_r;
    ptr_nxt = ptr_r;
    if (in_fire) begin
      rem_nxt = res_cnt;
      ptr_nxt = 2'd0;
    end else if (out_fire) begin
      rem_nxt = rem_r - 2'd1;
      ptr_nxt = (rem_r == 2'd1) ? ptr_r : ptr_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '{in_quote: 1'b0, quote_is_double: 1'b0, escape_pending: 1'b0,
                 in_comment: 1'b0, lookahead: qtt_pkg::LA_NONE, has_content: 1'b0};
      rem_r <= 2'd0;
      ptr_r <= 2'd0;
    end else begin
      if (in_fire) st_r <= st_nxt;
      rem_r <= rem_nxt;
      ptr_r <= ptr_nxt;
    end
  end

  // Load the results of an accepted transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < qtt_pkg::MAX_RESULTS; i++) begin
        buf_r[i] <= res_nxt[i];
      end
    end
  end

endmodule

FILE: test/tb_query_text_tokenizer.sv
`timescale 1ns / 1ps
// Self-checking testbench for query_text_tokenizer: directed and random query text,
// a scanner model that predicts every result, bursty sender, stalling receiver.
// Depends on qtt_pkg and the query_text_tokenizer RTL.
module tb_query_text_tokenizer;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned ITEMS_PER_PHASE = 50;
  localparam logic [qtt_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [qtt_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    logic [7:0] ch;
    logic       eoq;
  } query_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [8:0]  cfg_data = 9'd0;

  query_char_t      pending_chars[$];
  qtt_pkg::result_t expected_results[$];
  qtt_pkg::result_t step_results[$];

  // register shadows
  logic [3:0]  arg_count_q = 4'd0;
  logic [8:0]  arg_mask_q = 9'd0;

  // scanner state of the model
  logic                sc_in_quote = 1'b0;
  logic                sc_dquote = 1'b0;
  logic                sc_escape = 1'b0;
  logic                sc_comment = 1'b0;
  qtt_pkg::lookahead_t sc_held = qtt_pkg::LA_NONE;
  logic                sc_has_content = 1'b0;

  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  query_text_tokenizer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model

  task automatic put_result(input qtt_pkg::kind_t k, input logic [7:0] b,
                            input logic [3:0] idx);
    qtt_pkg::result_t r;
    r.kind = k;
    r.data = b;
    r.arg_index = idx;
    r.last = 1'b0;
    step_results.push_back(r);
  endtask

  task automatic put_token_byte(input logic [7:0] b);
    put_result(qtt_pkg::KIND_BYTE, b, 4'd0);
    sc_has_content = 1'b1;
  endtask

  task automatic tokenize_byte(input logic [7:0] c, input logic eoq);
    logic       consumed;
    logic [7:0] diff;
    logic [3:0] idx;
    logic [3:0] usable;
    consumed = 1'b0;
    step_results.delete();
    if (sc_comment) begin
      if (c == qtt_pkg::CH_LF) sc_comment = 1'b0;
      consumed = 1'b1;
    end else if (sc_held == qtt_pkg::LA_SLASH) begin
      sc_held = qtt_pkg::LA_NONE;
      if (c == qtt_pkg::CH_SLASH) begin
        sc_comment = 1'b1;
        consumed = 1'b1;
      end else begin
        put_token_byte(qtt_pkg::CH_SLASH);
      end
    end else if (sc_held == qtt_pkg::LA_PERCENT) begin
      sc_held = qtt_pkg::LA_NONE;
      if (c >= qtt_pkg::CH_DIGIT1 && c <= qtt_pkg::CH_DIGIT9) begin
        diff = c - qtt_pkg::CH_DIGIT1;
        idx = diff[3:0];
        usable = (arg_count_q > qtt_pkg::MAX_ARGS) ? 4'(qtt_pkg::MAX_ARGS) : arg_count_q;
        if (idx < usable) begin
          put_result(qtt_pkg::KIND_ARG, 8'd0, idx);
          if (arg_mask_q[idx]) sc_has_content = 1'b1;
        end
        consumed = 1'b1;
      end else begin
        put_token_byte(qtt_pkg::CH_PERCENT);
      end
    end else begin
      sc_held = qtt_pkg::LA_NONE;
    end

    if (!consumed) begin
      if (sc_escape) begin
        sc_escape = 1'b0;
        put_token_byte(c);
      end else if (c == qtt_pkg::CH_BSLASH) begin
        sc_escape = 1'b1;
      end else if (!sc_in_quote && (c == qtt_pkg::CH_SQUOTE || c == qtt_pkg::CH_DQUOTE)) begin
        sc_in_quote = 1'b1;
        sc_dquote = (c == qtt_pkg::CH_DQUOTE);
      end else if (sc_in_quote &&
                   c == (sc_dquote ? qtt_pkg::CH_DQUOTE : qtt_pkg::CH_SQUOTE)) begin
        // a closing quote ends the token even when it is empty
        sc_in_quote = 1'b0;
        put_result(qtt_pkg::KIND_END, 8'd0, 4'd0);
        sc_has_content = 1'b0;
      end else if (sc_in_quote) begin
        put_token_byte(c);
      end else if (c == qtt_pkg::CH_HASH) begin
        sc_comment = 1'b1;
      end else if (c == qtt_pkg::CH_SLASH) begin
        sc_held = qtt_pkg::LA_SLASH;
      end else if (c == qtt_pkg::CH_PERCENT) begin
        sc_held = qtt_pkg::LA_PERCENT;
      end else if (c == qtt_pkg::CH_SPACE || c == qtt_pkg::CH_TAB ||
                   c == qtt_pkg::CH_LF || c == qtt_pkg::CH_CR) begin
        if (sc_has_content) begin
          put_result(qtt_pkg::KIND_END, 8'd0, 4'd0);
          sc_has_content = 1'b0;
        end
      end else begin
        put_token_byte(c);
      end
    end

    if (eoq) begin
      // flush a held byte, drop escape, abandon quote or comment
      if (sc_held == qtt_pkg::LA_SLASH) put_token_byte(qtt_pkg::CH_SLASH);
      else if (sc_held == qtt_pkg::LA_PERCENT) put_token_byte(qtt_pkg::CH_PERCENT);
      if (sc_has_content) put_result(qtt_pkg::KIND_END, 8'd0, 4'd0);
      sc_in_quote = 1'b0;
      sc_dquote = 1'b0;
      sc_escape = 1'b0;
      sc_comment = 1'b0;
      sc_held = qtt_pkg::LA_NONE;
      sc_has_content = 1'b0;
    end

    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endtask

  // ---------------------------------------------------------------- driver

  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    query_char_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left != 0 || pending_chars.size() == 0) begin
        in_tvalid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        nxt = pending_chars.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= nxt.ch;
        in_tlast <= nxt.eoq;
        if (burst_left <= 1) begin
          // now and then a long run with no gaps at all
          if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(20, 40);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left = $urandom_range(0, 5);
          end
        end else begin
          burst_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  logic [7:0]  stall_pattern = 8'b1011_0010;

  always @(posedge clk) begin
    qtt_pkg::result_t exp_r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) tokenize_byte(in_tdata, in_tlast);

      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d tdata %04h last %0d",
                     out_tuser, out_tdata, out_tlast);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_tuser !== exp_r.kind || out_tdata[7:0] !== exp_r.data ||
              out_tdata[11:8] !== exp_r.arg_index || out_tdata[15:12] !== 4'd0 ||
              out_tlast !== exp_r.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected kind %0d byte %02h arg %0d last %0d",
                       exp_r.kind, exp_r.data, exp_r.arg_index, exp_r.last);
              $display("  got kind %0d byte %02h arg %0d pad %0h last %0d",
                       out_tuser, out_tdata[7:0], out_tdata[11:8], out_tdata[15:12],
                       out_tlast);
            end
          end
        end
      end

      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 1) == 1);
        2: out_tready <= ($urandom_range(0, 5) == 0);
        default: out_tready <= stall_pattern[0];
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic queue_byte(input logic [7:0] c, input logic eoq);
    query_char_t q;
    q.ch = c;
    q.eoq = eoq;
    pending_chars.push_back(q);
  endtask

  task automatic queue_text(input string s, input logic eoq);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], eoq && (i == s.len() - 1));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == qtt_pkg::REG_ARG_COUNT) arg_count_q = val[3:0];
    else if (idx == qtt_pkg::REG_ARG_MASK) arg_mask_q = val;
  endtask

  task automatic wait_idle();
    while (pending_chars.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    // bytes that cause nothing may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range(8'h61, 8'h7a));
      1: return 8'($urandom_range(8'h41, 8'h5a));
      default: return 8'($urandom_range(8'h30, 8'h39));
    endcase
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0: return qtt_pkg::CH_SPACE;
      1: return qtt_pkg::CH_TAB;
      2: return qtt_pkg::CH_LF;
      default: return qtt_pkg::CH_CR;
    endcase
  endfunction

  // Build one query, mostly well formed, and return how many bytes it queued.
  task automatic queue_random_query(output int unsigned n);
    logic [7:0] q[$];
    int unsigned pieces;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
    end else begin
      pieces = $urandom_range(1, 6);
      repeat (pieces) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 4)) q.push_back(word_char());
          1: begin
            q.push_back(qtt_pkg::CH_SQUOTE);
            repeat ($urandom_range(0, 3)) q.push_back(word_char());
            if ($urandom_range(0, 5) != 0) q.push_back(qtt_pkg::CH_SQUOTE);
          end
          2: begin
            q.push_back(qtt_pkg::CH_DQUOTE);
            repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 5) != 0) q.push_back(qtt_pkg::CH_DQUOTE);
          end
          3: begin
            q.push_back(qtt_pkg::CH_PERCENT);
            q.push_back(8'($urandom_range(qtt_pkg::CH_DIGIT1, qtt_pkg::CH_DIGIT9)));
          end
          4: begin
            q.push_back(qtt_pkg::CH_PERCENT);
            q.push_back(8'($urandom_range(0, 255)));
          end
          5: begin
            q.push_back(qtt_pkg::CH_BSLASH);
            q.push_back(8'($urandom_range(0, 255)));
          end
          6: begin
            q.push_back(qtt_pkg::CH_HASH);
            repeat ($urandom_range(0, 3)) q.push_back(word_char());
            q.push_back(qtt_pkg::CH_LF);
          end
          7: begin
            q.push_back(qtt_pkg::CH_SLASH);
            q.push_back(qtt_pkg::CH_SLASH);
            repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range(0, 255)));
            q.push_back(qtt_pkg::CH_LF);
          end
          8: q.push_back(blank_char());
          default: begin
            q.push_back(qtt_pkg::CH_SLASH);
            q.push_back(8'($urandom_range(0, 255)));
          end
        endcase
        if ($urandom_range(0, 1) == 0) q.push_back(blank_char());
      end
    end
    n = q.size();
    foreach (q[i]) queue_byte(q[i], i == q.size() - 1);
  endtask

  task automatic run_random_phase();
    int unsigned queued;
    int unsigned n;
    queued = 0;
    while (queued < ITEMS_PER_PHASE) begin
      queue_random_query(n);
      queued += n;
    end
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // four arguments, the second and fourth of them empty; upper data bits ignored for the count
    write_reg(qtt_pkg::REG_ARG_COUNT, 9'h1E4);
    write_reg(qtt_pkg::REG_ARG_MASK, 9'h005);

    // inserts below the count and one above it, held slash before a letter and at the end
    queue_byte(8'hFF, 1'b0);
    queue_text("%1%2%5/b/", 1'b1);
    // hash comment, empty quoted token, unclosed quote, escape dropped at the end
    queue_text("#x\n\"\"'a\\", 1'b1);
    // slash comment, percent before a non-digit, zero byte, escaped blank, held percent
    queue_text("//\n%a\t", 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_text("\\ %", 1'b1);
    wait_idle();

    write_reg(qtt_pkg::REG_ARG_COUNT, 9'd9);
    write_reg(qtt_pkg::REG_ARG_MASK, 9'h1FF);
    run_random_phase();

    write_reg(qtt_pkg::REG_ARG_COUNT, 9'd0);
    write_reg(qtt_pkg::REG_ARG_MASK, 9'h000);
    write_reg(REG_SPARE_A, 9'h1FF);
    write_reg(REG_SPARE_B, 9'h155);
    run_random_phase();

    // a count above the limit behaves as the limit
    write_reg(qtt_pkg::REG_ARG_COUNT, 9'h1FF);
    write_reg(qtt_pkg::REG_ARG_MASK, 9'h0AA);
    run_random_phase();

    write_reg(qtt_pkg::REG_ARG_COUNT, 9'($urandom_range(0, 511)));
    write_reg(qtt_pkg::REG_ARG_MASK, 9'($urandom_range(0, 511)));
    run_random_phase();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
src/qtt_pkg.sv
src/query_text_tokenizer.sv
test/tb_query_text_tokenizer.sv
